### hw/rtl/ctd_pkg.sv
// Shared types for the Cantor tuple decoder.
// Input and result item layouts; no dependencies.
`default_nettype none

package ctd_pkg;

    typedef struct packed {
        logic [31:0] code;
        logic [3:0]  arity;
    } in_item_t;

    typedef struct packed {
        logic [31:0] element;
        logic        last;
    } out_item_t;

    localparam int CODE_IN_W = 32;
    localparam int ARITY_W   = 4;
    localparam int ELEM_W    = 32;

endpackage

`default_nettype wire

### hw/rtl/ctd_front.sv
// Front end: accepts input items, masks the code and clamps the arity.
// Uses ctd_pkg; feeds ctd_queue.
`default_nettype none

module ctd_front #(
    parameter int MAX_ARITY = 8,
    parameter int CW        = 32
) (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire                logic in_valid,
    output logic               in_ready,
    input  ctd_pkg::in_item_t  in_item,
    output logic               push_valid,
    input  wire                logic push_ready,
    output logic [CW+4-1:0]    push_data
);
    import ctd_pkg::*;

    localparam int                 CAP_I = (MAX_ARITY < 15) ? MAX_ARITY : 15;
    localparam logic [ARITY_W-1:0] CAP   = ARITY_W'(CAP_I);

    logic               valid_reg;
    logic [CW-1:0]      code_reg;
    logic [ARITY_W-1:0] count_reg;
    logic [ARITY_W-1:0] count_next;

    always_comb
    begin
        count_next = in_item.arity;
        if (in_item.arity == '0)
        begin
            count_next = ARITY_W'(1);
        end
        else if (in_item.arity > CAP)
        begin
            count_next = CAP;
        end
    end

    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_data  = {count_reg, code_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            code_reg  <= in_item.code[CW-1:0];
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ctd_queue.sv
// Two-entry queue between front and back ends.
// Standalone; payload width set by parameter.
`default_nettype none

module ctd_queue #(
    parameter int WIDTH = 36
) (
    input  wire              logic clk,
    input  wire              logic rst_n,
    input  wire              logic push_valid,
    output logic             push_ready,
    input  wire [WIDTH-1:0]  push_data,
    output logic             pop_valid,
    input  wire              logic pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ctd_root.sv
// Iterative triangular root: largest j with j(j+1)/2 <= v, one bit per cycle.
// T(j) is built incrementally: T(j+d) = T(j) + d*j + T(d), d a power of two.
// Standalone; used by ctd_back.
`default_nettype none

module ctd_root #(
    parameter int CW = 32
) (
    input  wire              logic clk,
    input  wire              logic rst_n,
    input  wire              logic start,
    input  wire [CW-1:0]     value,
    output logic             done,
    output logic [(CW+2)/2-1:0] root,
    output logic [CW-1:0]    rem
);
    localparam int RB = (CW + 2) / 2;      // root bits
    localparam int TW = 2 * RB + 1;        // triangular number width
    localparam int BW = (RB > 1) ? $clog2(RB) : 1;

    logic          busy_reg;
    logic [BW-1:0] bit_reg;
    logic [CW-1:0] v_reg;
    logic [RB-1:0] j_reg;
    logic [TW-1:0] t_reg;

    logic [TW-1:0] pow;
    logic [TW-1:0] tri_pow;
    logic [TW-1:0] t_cand;
    logic          take;

    always_comb
    begin
        pow     = TW'(1) << bit_reg;
        tri_pow = ((pow << bit_reg) + pow) >> 1;
        t_cand  = t_reg + (TW'(j_reg) << bit_reg) + tri_pow;
        take    = (t_cand <= TW'(v_reg));
    end

    assign done = !busy_reg;
    assign root = j_reg;
    assign rem  = CW'(TW'(v_reg) - t_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && bit_reg == '0)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= value;
            j_reg   <= '0;
            t_reg   <= '0;
            bit_reg <= BW'(RB - 1);
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                j_reg <= j_reg | RB'(pow);
                t_reg <= t_cand;
            end
            bit_reg <= bit_reg - BW'(1);
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ctd_back.sv
// Back end: pops items, runs the root unit per non-last element, drives results.
// Uses ctd_pkg and ctd_root.
`default_nettype none

module ctd_back #(
    parameter int CW = 32
) (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire                logic pop_valid,
    output logic               pop_ready,
    input  wire [CW+4-1:0]     pop_data,
    output logic               out_valid,
    input  wire                logic out_ready,
    output ctd_pkg::out_item_t out_item
);
    import ctd_pkg::*;

    localparam int RB = (CW + 2) / 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SOLVE,
        ST_LAST
    } state_t;

    state_t             state_reg;
    logic [CW-1:0]      code_reg;
    logic [ARITY_W-1:0] left_reg;
    logic               out_valid_reg;
    out_item_t          out_item_reg;

    logic [CW-1:0]      q_code;
    logic [ARITY_W-1:0] q_count;
    logic               slot_free;
    logic               advance;
    logic               out_fire;
    logic               root_start;
    logic [CW-1:0]      root_value;
    logic               root_done;
    logic [RB-1:0]      root_j;
    logic [CW-1:0]      root_rem;

    assign q_code    = pop_data[CW-1:0];
    assign q_count   = pop_data[CW+4-1:CW];
    assign slot_free = !out_valid_reg || out_ready;
    assign pop_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // one element done and the output slot can take it
    assign advance = (state_reg == ST_SOLVE) && root_done && slot_free;

    // a new element enters the output register this cycle
    assign out_fire = advance || ((state_reg == ST_LAST) && slot_free);

    assign root_start = ((state_reg == ST_IDLE) && pop_valid && q_count != ARITY_W'(1))
                     || (advance && left_reg != ARITY_W'(2));
    assign root_value = (state_reg == ST_IDLE) ? q_code : root_rem;

    ctd_root #(
        .CW (CW)
    ) u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .value (root_value),
        .done  (root_done),
        .root  (root_j),
        .rem   (root_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            code_reg      <= '0;
            left_reg      <= '0;
            out_item_reg  <= '0;
        end
        else
        begin
            if (out_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop_valid)
                    begin
                        code_reg  <= q_code;
                        left_reg  <= q_count;
                        state_reg <= (q_count == ARITY_W'(1)) ? ST_LAST : ST_SOLVE;
                    end
                end
                ST_SOLVE:
                begin
                    if (advance)
                    begin
                        out_item_reg.element <= ELEM_W'(root_j) - ELEM_W'(root_rem);
                        out_item_reg.last    <= 1'b0;
                        code_reg             <= root_rem;
                        left_reg             <= left_reg - ARITY_W'(1);
                        if (left_reg == ARITY_W'(2))
                        begin
                            state_reg <= ST_LAST;
                        end
                    end
                end
                ST_LAST:
                begin
                    if (slot_free)
                    begin
                        out_item_reg.element <= ELEM_W'(code_reg);
                        out_item_reg.last    <= 1'b1;
                        state_reg            <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/cantor_tuple_decode.sv
// Top level of the Cantor tuple decoder: front end, item queue, back end.
// Uses ctd_pkg, ctd_front, ctd_queue, ctd_back.
//
//  channel | signals                       | carries
//  --------+-------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_item   | code, arity (one tuple)
//  out     | out_valid, out_ready, out_item| element, last (one per element)
//
// Each of the first n-1 elements takes one root search and then a load of the
// output register; the last element is loaded from the remaining code, and
// the next item is popped after it.
// The queue holds two items, so the front keeps accepting while the back works.
// Reset clears all handshake and sequencer state; no clearing pass.
// A stalled output holds the sequencer before the next element is loaded.
`default_nettype none

module cantor_tuple_decode #(
    parameter int MAX_ARITY = 8,
    parameter int CODE_BITS = 32
) (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire                logic in_valid,
    output logic               in_ready,
    input  ctd_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  wire                logic out_ready,
    output ctd_pkg::out_item_t out_item
);
    import ctd_pkg::*;

    localparam int CW = (CODE_BITS < CODE_IN_W) ? CODE_BITS : CODE_IN_W;
    localparam int QW = CW + ARITY_W;

    logic          push_valid;
    logic          push_ready;
    logic [QW-1:0] push_data;
    logic          pop_valid;
    logic          pop_ready;
    logic [QW-1:0] pop_data;

    ctd_front #(
        .MAX_ARITY (MAX_ARITY),
        .CW        (CW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    ctd_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ctd_back #(
        .CW (CW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire
